>>> hdl/onewire_rom_search_core_defines.svh
// assertion macros for the onewire rom search core checker
// no dependencies; included by files that hold concurrent assertions
`ifndef ONEWIRE_ROM_SEARCH_CORE_DEFINES_SVH
`define ONEWIRE_ROM_SEARCH_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define ORS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ors check failed");

// next-cycle implication, disabled while reset is low
`define ORS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ors check failed");

`endif

>>> hdl/ors_pkg.sv
// shared types, constants and crc helper for the onewire rom search core
// no dependencies
`default_nettype none

package ors_pkg;

  localparam int unsigned ROM_W = 64;

  localparam logic [7:0] CRC_POLY      = 8'h8C;
  localparam logic [7:0] FAMILY_RESET  = 8'h28;
  localparam logic [6:0] FAMILY_LIMIT  = 7'd9;
  // last rom bit position covered by the crc (bytes 0..6)
  localparam logic [6:0] CRC_LAST_POS  = 7'd56;

  typedef enum logic [1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_TARGET   = 2'd1,
    CMD_START    = 2'd2,
    CMD_BIT_PAIR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OUTC_NONE  = 2'd0,
    OUTC_FOUND = 2'd1,
    OUTC_FAIL  = 2'd2
  } outcome_t;

  typedef struct packed {
    logic [ROM_W-1:0] rom_bits;
    logic [6:0]       prior_disc;
    logic [3:0]       family_mark;
    logic             done_flag;
    logic [6:0]       bit_pos;
    logic [6:0]       zero_branch;
    logic             pass_active;
    logic [7:0]       crc_run;
  } search_state_t;

  localparam search_state_t STATE_RESET = '{
    rom_bits:    '0,
    prior_disc:  7'd0,
    family_mark: 4'd0,
    done_flag:   1'b0,
    bit_pos:     7'd1,
    zero_branch: 7'd0,
    pass_active: 1'b0,
    crc_run:     8'd0
  };

  typedef struct packed {
    logic             write_valid;
    logic             write_value;
    outcome_t         outcome;
    logic [ROM_W-1:0] rom_value;
    logic             crc_good;
    logic             final_device;
    logic [3:0]       family_branch;
  } step_result_t;

  // one bit of the reflected crc-8, lsb first
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic din);
    logic [7:0] res;
    res = crc >> 1;
    if (crc[0] ^ din) begin
      res = res ^ CRC_POLY;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hdl/onewire_rom_search_core.sv
// path: an accepted transaction passes through the input register, then the result register, which presents it
// throughput: one transaction per cycle, limited only by out_ready backpressure
// the input register and the result register each hold one transaction
// reset: synchronous, active low; clears search state and both stages,
// target_family returns to 0x28
// depends on ors_pkg and ors_step_logic
`default_nettype none

module onewire_rom_search_core #(
  parameter int unsigned ROM_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  // command channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic        in_presence,
  input  wire logic        in_id_bit,
  input  wire logic        in_comp_bit,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_write_valid,
  output logic             out_write_value,
  output logic [1:0]       out_outcome,
  output logic [63:0]      out_rom_value,
  output logic             out_crc_good,
  output logic             out_final_device,
  output logic [3:0]       out_family_branch
);

  // target family register
  logic [7:0] target_family_r;

  // input stage: holds one accepted transaction
  logic       s1_valid_r, s1_valid_nxt;
  logic [1:0] s1_cmd_r;
  logic       s1_presence_r;
  logic       s1_id_bit_r;
  logic       s1_comp_bit_r;

  // result stage
  logic                  out_valid_r, out_valid_nxt;
  ors_pkg::step_result_t out_res_r;

  // search state, updated when a transaction moves into the result stage
  ors_pkg::search_state_t state_r, state_nxt;
  ors_pkg::step_result_t  step_res;

  logic out_load;   // result stage can take a new transaction
  logic s1_adv;     // input stage hands its transaction on
  logic in_acc;

  assign out_load = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_load;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_ready);

  ors_step_logic #(
    .ROM_BITS (ROM_BITS)
  ) u_step (
    .cmd           (ors_pkg::cmd_t'(s1_cmd_r)),
    .presence      (s1_presence_r),
    .id_bit        (s1_id_bit_r),
    .comp_bit      (s1_comp_bit_r),
    .target_family (target_family_r),
    .st            (state_r),
    .st_nxt        (state_nxt),
    .res           (step_res)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      state_r         <= ors_pkg::STATE_RESET;
      target_family_r <= ors_pkg::FAMILY_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        state_r <= state_nxt;
      end
      if (cfg_wr_en) begin
        target_family_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r        <= in_command;
      s1_presence_r   <= in_presence;
      s1_id_bit_r     <= in_id_bit;
      s1_comp_bit_r   <= in_comp_bit;
    end
    if (s1_adv) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_valid   = out_res_r.write_valid;
  assign out_write_value   = out_res_r.write_value;
  assign out_outcome       = out_res_r.outcome;
  assign out_rom_value     = out_res_r.rom_value;
  assign out_crc_good      = out_res_r.crc_good;
  assign out_final_device  = out_res_r.final_device;
  assign out_family_branch = out_res_r.family_branch;

endmodule

`default_nettype wire

>>> hdl/ors_step_logic.sv
// combinational next-state and result logic for one search transaction
// depends on ors_pkg
`default_nettype none

module ors_step_logic #(
  parameter int unsigned ROM_BITS = 64
) (
  input  wire ors_pkg::cmd_t          cmd,
  input  wire logic                   presence,
  input  wire logic                   id_bit,
  input  wire logic                   comp_bit,
  input  wire logic [7:0]             target_family,
  input  wire ors_pkg::search_state_t st,
  output ors_pkg::search_state_t      st_nxt,
  output ors_pkg::step_result_t       res
);

  localparam logic [6:0] LAST_POS = 7'(ROM_BITS);
  // zero bits the crc still has to absorb when the rom is shorter than 56 bits
  localparam int unsigned PAD_BITS =
    (ROM_BITS < 56) ? (56 - ROM_BITS) : 0;

  logic [6:0] pos;
  logic [5:0] sh;
  logic       dir;
  logic [7:0] crc_fin;

  always_comb begin
    st_nxt  = st;
    res     = '0;
    res.outcome = ors_pkg::OUTC_NONE;
    pos     = st.bit_pos;
    sh      = 6'(st.bit_pos - 7'd1);
    dir     = 1'b0;
    crc_fin = 8'd0;

    unique case (cmd)
      ors_pkg::CMD_CLEAR: begin
        st_nxt.rom_bits    = '0;
        st_nxt.prior_disc  = 7'd0;
        st_nxt.family_mark = 4'd0;
        st_nxt.done_flag   = 1'b0;
        st_nxt.pass_active = 1'b0;
        st_nxt.bit_pos     = 7'd1;
        st_nxt.zero_branch = 7'd0;
      end
      ors_pkg::CMD_TARGET: begin
        st_nxt.rom_bits    = {{(ors_pkg::ROM_W-8){1'b0}}, target_family};
        st_nxt.prior_disc  = LAST_POS;
        st_nxt.family_mark = 4'd0;
        st_nxt.done_flag   = 1'b0;
        st_nxt.pass_active = 1'b0;
      end
      ors_pkg::CMD_START: begin
        st_nxt.bit_pos     = 7'd1;
        st_nxt.zero_branch = 7'd0;
        st_nxt.crc_run     = 8'd0;
        if (st.done_flag || !presence) begin
          st_nxt.prior_disc  = 7'd0;
          st_nxt.family_mark = 4'd0;
          st_nxt.done_flag   = 1'b0;
          st_nxt.pass_active = 1'b0;
          res.outcome        = ors_pkg::OUTC_FAIL;
        end else begin
          st_nxt.pass_active = 1'b1;
        end
      end
      ors_pkg::CMD_BIT_PAIR: begin
        if (st.pass_active) begin
          if (id_bit && comp_bit) begin
            // no device answered: abort the pass
            st_nxt.prior_disc  = 7'd0;
            st_nxt.family_mark = 4'd0;
            st_nxt.done_flag   = 1'b0;
            st_nxt.pass_active = 1'b0;
            res.outcome        = ors_pkg::OUTC_FAIL;
          end else begin
            if (id_bit != comp_bit) begin
              dir = id_bit;
            end else begin
              // discrepancy: follow the previous path, then take one
              if (pos < st.prior_disc) begin
                dir = st.rom_bits[sh];
              end else begin
                dir = (pos == st.prior_disc);
              end
              if (!dir) begin
                st_nxt.zero_branch = pos;
                if (pos < ors_pkg::FAMILY_LIMIT) begin
                  st_nxt.family_mark = 4'(pos);
                end
              end
            end
            st_nxt.rom_bits[sh] = dir;
            if (pos <= ors_pkg::CRC_LAST_POS) begin
              st_nxt.crc_run = ors_pkg::crc_step(st.crc_run, dir);
            end
            st_nxt.bit_pos  = pos + 7'd1;
            res.write_valid = 1'b1;
            res.write_value = dir;

            if (pos >= LAST_POS) begin
              st_nxt.pass_active = 1'b0;
              st_nxt.prior_disc  = st_nxt.zero_branch;
              st_nxt.done_flag   = (st_nxt.zero_branch == 7'd0);
              if (st_nxt.rom_bits[7:0] == 8'd0) begin
                st_nxt.prior_disc  = 7'd0;
                st_nxt.family_mark = 4'd0;
                st_nxt.done_flag   = 1'b0;
                res.outcome        = ors_pkg::OUTC_FAIL;
              end else begin
                // constant zero padding folds to a fixed xor map
                crc_fin = st_nxt.crc_run;
                for (int i = 0; i < PAD_BITS; i++) begin
                  crc_fin = ors_pkg::crc_step(crc_fin, 1'b0);
                end
                res.outcome      = ors_pkg::OUTC_FOUND;
                res.rom_value    = st_nxt.rom_bits;
                res.crc_good     = (crc_fin == st_nxt.rom_bits[63:56]);
                res.final_device = (st_nxt.zero_branch == 7'd0);
              end
            end
          end
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase

    res.family_branch = st_nxt.family_mark;
  end

endmodule

`default_nettype wire

>>> hdl/ors_checker.sv
// port-level checks on the onewire rom search core, bound to the top level
// depends on ors_pkg, onewire_rom_search_core_defines.svh and onewire_rom_search_core
`default_nettype none
`include "onewire_rom_search_core_defines.svh"

module ors_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_write_valid,
  input wire logic        out_write_value,
  input wire logic [1:0]  out_outcome,
  input wire logic [63:0] out_rom_value,
  input wire logic        out_crc_good,
  input wire logic        out_final_device,
  input wire logic [3:0]  out_family_branch
);

  // a stalled result transaction stays valid and holds its rom code and outcome
  `ORS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_rom_value) && $stable(out_outcome))

  // rom code, crc and last-device flag only accompany a found device
  `ORS_ASSERT_NOW(a_found_only, clk, rst_n, out_valid && out_outcome != ors_pkg::OUTC_FOUND,
    out_rom_value == 64'd0 && !out_crc_good && !out_final_device)

  // direction bit is zero unless a write is requested
  `ORS_ASSERT_NOW(a_dir_gated, clk, rst_n, out_valid && !out_write_valid,
    !out_write_value)

  // family branch never points beyond the family byte, outcome code in range
  `ORS_ASSERT_NOW(a_ranges, clk, rst_n, out_valid,
    out_family_branch <= 4'd8 && out_outcome <= ors_pkg::OUTC_FAIL)

endmodule

bind onewire_rom_search_core ors_checker u_ors_checker (.*);

`default_nettype wire
